// ----- rtl/landing_detect_recovery_beacon_defines.svh -----
// ---------------------------------------------------------------------------
// landing detector assertion macros
// shared property forms for the checker of the recovery beacon block
// ---------------------------------------------------------------------------
`ifndef LANDING_DETECT_RECOVERY_BEACON_DEFINES_SVH
`define LANDING_DETECT_RECOVERY_BEACON_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define LRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrb check failed");

// next-cycle implication, off while reset is asserted
`define LRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrb check failed");

`endif

// ----- rtl/lrb_pkg.sv -----
// ---------------------------------------------------------------------------
// lrb_pkg
// types, register map and constants of the landing detector and beacon
// ---------------------------------------------------------------------------
package lrb_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic [1:0] LAND_BEEPS       = 2'd3;
	localparam logic [9:0] LAND_BEEP_MS     = 10'd500;
	localparam logic [1:0] RECOVERY_BEEPS   = 2'd2;
	localparam logic [9:0] RECOVERY_BEEP_MS = 10'd1000;

	localparam logic [15:0] CHECK_PERIOD_RST  = 16'd1000;
	localparam logic [11:0] DRIFT_LIMIT_RST   = 12'd32;
	localparam logic [15:0] SPEED_LIMIT_RST   = 16'd240;
	localparam logic [31:0] STABLE_WINDOW_RST = 32'd10000;
	localparam logic [31:0] ALARM_DELAY_RST   = 32'd900000;
	localparam logic [15:0] BEEP_INTERVAL_RST = 16'd3000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHECK_PERIOD  = 3'd0,
		CFG_DRIFT_LIMIT   = 3'd1,
		CFG_SPEED_LIMIT   = 3'd2,
		CFG_STABLE_WINDOW = 3'd3,
		CFG_ALARM_DELAY   = 3'd4,
		CFG_BEEP_INTERVAL = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] check_period_ms;
		logic [11:0] drift_limit;
		logic [15:0] speed_limit;
		logic [31:0] stable_window_ms;
		logic [31:0] alarm_delay_ms;
		logic [15:0] beep_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic               past_apogee;
		logic signed [23:0] altitude;
		logic [15:0]        gps_speed;
		logic               gps_valid;
	} item_t;

	typedef struct packed {
		logic       landed;
		logic [1:0] beep_count;
		logic [9:0] beep_length_ms;
	} result_t;

endpackage

// ----- rtl/lrb_cfg.sv -----
// ---------------------------------------------------------------------------
// lrb_cfg
// configuration register file, written through the index/data channel
// ---------------------------------------------------------------------------
module lrb_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lrb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lrb_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lrb_pkg::cfg_t                     cfg
);

	lrb_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_period_ms  <= lrb_pkg::CHECK_PERIOD_RST;
			cfg_q.drift_limit      <= lrb_pkg::DRIFT_LIMIT_RST;
			cfg_q.speed_limit      <= lrb_pkg::SPEED_LIMIT_RST;
			cfg_q.stable_window_ms <= lrb_pkg::STABLE_WINDOW_RST;
			cfg_q.alarm_delay_ms   <= lrb_pkg::ALARM_DELAY_RST;
			cfg_q.beep_interval_ms <= lrb_pkg::BEEP_INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lrb_pkg::CFG_CHECK_PERIOD:  cfg_q.check_period_ms  <= cfg_data[15:0];
				lrb_pkg::CFG_DRIFT_LIMIT:   cfg_q.drift_limit      <= cfg_data[11:0];
				lrb_pkg::CFG_SPEED_LIMIT:   cfg_q.speed_limit      <= cfg_data[15:0];
				lrb_pkg::CFG_STABLE_WINDOW: cfg_q.stable_window_ms <= cfg_data[31:0];
				lrb_pkg::CFG_ALARM_DELAY:   cfg_q.alarm_delay_ms   <= cfg_data[31:0];
				lrb_pkg::CFG_BEEP_INTERVAL: cfg_q.beep_interval_ms <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/lrb_core.sv -----
// ---------------------------------------------------------------------------
// lrb_core
// landing decision state and single-pass evaluation of one word
// ---------------------------------------------------------------------------
module lrb_core #(
	parameter int TIME_BITS = lrb_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lrb_pkg::cfg_t    cfg,
	input  lrb_pkg::item_t   item,
	input  logic             fire,
	output lrb_pkg::result_t res
);

	localparam int CmpW = (TIME_BITS > 32) ? TIME_BITS : 32;

	logic                 landed_q;
	logic [TIME_BITS-1:0] last_check_q;
	logic signed [23:0]   anchor_q;
	logic [TIME_BITS-1:0] stable_start_q;
	logic                 stable_run_q;
	logic [TIME_BITS-1:0] landing_q;
	logic [TIME_BITS-1:0] last_beep_q;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] el_chk;
	logic [TIME_BITS-1:0] el_stab;
	logic [TIME_BITS-1:0] el_land;
	logic [TIME_BITS-1:0] el_beep;
	logic signed [24:0]   diff;
	logic [24:0]          drift;
	logic                 eval;
	logic                 moving;
	logic                 restart;
	logic                 window_done;
	logic                 alarm;
	logic                 do_restart;
	logic                 do_land;
	logic                 do_beep;

	// time differences wrap at the timer width
	assign now_t   = TIME_BITS'(item.now_ms);
	assign el_chk  = now_t - last_check_q;
	assign el_stab = now_t - stable_start_q;
	assign el_land = now_t - landing_q;
	assign el_beep = now_t - last_beep_q;

	assign diff  = 25'(item.altitude) - 25'(anchor_q);
	assign drift = diff[24] ? 25'(-diff) : 25'(diff);

	assign eval        = item.past_apogee &&
	                     (CmpW'(el_chk) >= CmpW'(cfg.check_period_ms));
	assign moving      = item.gps_valid && (item.gps_speed > cfg.speed_limit);
	assign restart     = !stable_run_q || (drift > 25'(cfg.drift_limit));
	assign window_done = CmpW'(el_stab) > CmpW'(cfg.stable_window_ms);
	assign alarm       = (CmpW'(el_land) > CmpW'(cfg.alarm_delay_ms)) &&
	                     (CmpW'(el_beep) > CmpW'(cfg.beep_interval_ms));

	assign do_restart = eval && !landed_q && restart;
	assign do_land    = eval && !landed_q && !restart && window_done;
	assign do_beep    = eval && landed_q && alarm;

	always_comb begin
		res.landed         = landed_q || do_land;
		res.beep_count     = 2'd0;
		res.beep_length_ms = 10'd0;
		if (do_land) begin
			res.beep_count     = lrb_pkg::LAND_BEEPS;
			res.beep_length_ms = lrb_pkg::LAND_BEEP_MS;
		end else if (do_beep) begin
			res.beep_count     = lrb_pkg::RECOVERY_BEEPS;
			res.beep_length_ms = lrb_pkg::RECOVERY_BEEP_MS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			landed_q       <= 1'b0;
			last_check_q   <= '0;
			anchor_q       <= '0;
			stable_start_q <= '0;
			stable_run_q   <= 1'b0;
			landing_q      <= '0;
			last_beep_q    <= '0;
		end else if (fire) begin
			if (eval) begin
				last_check_q <= now_t;
			end
			if (do_restart) begin
				anchor_q       <= item.altitude;
				stable_start_q <= now_t;
				// fast motion keeps the timer stopped
				stable_run_q   <= !moving;
			end
			if (do_land) begin
				landed_q  <= 1'b1;
				landing_q <= now_t;
			end
			if (do_beep) begin
				last_beep_q <= now_t;
			end
		end
	end

endmodule

// ----- rtl/landing_detect_recovery_beacon.sv -----
// ---------------------------------------------------------------------------
// landing_detect_recovery_beacon
// post-apogee landing detector with landing and recovery beep requests
// ---------------------------------------------------------------------------
// Input words arrive on the s_axis channel (tdata: time, apogee flag,
// altitude, GPS speed; tuser: GPS validity) and each one yields exactly one
// result word on m_axis (landed state, beep count, beep length).
// The cfg channel writes the six settings by index; cfg_ready is always
// high, and writes are meant to happen while no word is in flight.
// A word passes the input register, then the decision logic feeding the
// output register, where m_axis_tvalid rises. Throughput is one word per
// clock barring receiver stalls; the limit is the single decision stage,
// whose state registers update in the cycle a word moves to the output.
// When the receiver stalls, the output register holds its word and the
// input register still takes one more word; s_axis_tready drops only when
// both are full.
// Reset clears both stages, the landing state and all timers, and loads
// the default settings.
// ---------------------------------------------------------------------------
module landing_detect_recovery_beacon #(
	parameter int TIME_BITS = lrb_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [31:0] now_ms, [32] past_apogee, [56:33] altitude,
	// [72:57] gps_speed, [79:73] zero
	input  logic [79:0]                    s_axis_tdata,
	// [0] gps_valid
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] landed, [2:1] beep_count, [12:3] beep_length_ms, [15:13] zero
	output logic [15:0]                    m_axis_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrb_pkg::CFG_DATA_W-1:0] cfg_data
);

	lrb_pkg::cfg_t    cfg;
	lrb_pkg::item_t   item_in;
	lrb_pkg::item_t   item_s1;
	logic             vld_s1;
	lrb_pkg::result_t res;
	lrb_pkg::result_t res_s2;
	logic             vld_s2;
	logic             fire;

	assign item_in.now_ms      = s_axis_tdata[31:0];
	assign item_in.past_apogee = s_axis_tdata[32];
	assign item_in.altitude    = $signed(s_axis_tdata[56:33]);
	assign item_in.gps_speed   = s_axis_tdata[72:57];
	assign item_in.gps_valid   = s_axis_tuser;

	// word moves to the output when the output slot is free or draining
	assign fire          = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || fire;

	lrb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lrb_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {3'b000, res_s2.beep_length_ms, res_s2.beep_count, res_s2.landed};

endmodule

// ----- rtl/lrb_checker.sv -----
// ---------------------------------------------------------------------------
// lrb_checker
// port-level checks of the landing detector, bound to the top level
// ---------------------------------------------------------------------------
`include "landing_detect_recovery_beacon_defines.svh"

module lrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	logic landed_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			landed_seen_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[0]) begin
			landed_seen_q <= 1'b1;
		end
	end

	`LRB_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// landing is sticky until reset
	`LRB_ASSERT_IMP(a_landed_sticky, clk, arst_n, m_axis_tvalid && landed_seen_q,
		m_axis_tdata[0])

	// a beep request pairs the right count and length, and needs landing
	`LRB_ASSERT_IMP(a_beep_pair, clk, arst_n, m_axis_tvalid,
		(m_axis_tdata[2:1] == 2'd0 && m_axis_tdata[12:3] == 10'd0) ||
		(m_axis_tdata[2:1] == 2'd3 && m_axis_tdata[12:3] == 10'd500 && m_axis_tdata[0]) ||
		(m_axis_tdata[2:1] == 2'd2 && m_axis_tdata[12:3] == 10'd1000 && m_axis_tdata[0]))

	// the landing request comes only on the first landed word
	`LRB_ASSERT_IMP(a_land_once, clk, arst_n, m_axis_tvalid && landed_seen_q,
		m_axis_tdata[2:1] != 2'd3)

endmodule

bind landing_detect_recovery_beacon lrb_checker u_lrb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
